### rtl/lftc_pkg.sv
// Shared constants, types and sequencer states of the line term-frequency counter.
package lftc_pkg;

  localparam int VOCAB_SIZE   = 4096;
  localparam int MAX_DISTINCT = 64;
  localparam int COUNT_BITS   = 16;

  localparam int VOCAB_AW = (VOCAB_SIZE > 1) ? $clog2(VOCAB_SIZE) : 1;
  localparam int LIST_AW  = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;

  localparam int ID_W    = 12;
  localparam int TOTAL_W = 7;
  localparam int NUM_W   = 13;
  localparam int OCC_W   = 16;

  typedef logic [COUNT_BITS-1:0] count_t;
  localparam count_t COUNT_MAX = '1;
  localparam logic [OCC_W-1:0] OCC_MAX = '1;

  typedef struct packed {
    logic [TOTAL_W-1:0] distinct_total;
    logic [NUM_W-1:0]   word_number;
    logic [OCC_W-1:0]   occurrences;
    logic               overflow;
    logic               last_of_line;
  } res_t;

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_RMW     = 7'b0000100,
    ST_EMPTY   = 7'b0001000,
    ST_DR_LIST = 7'b0010000,
    ST_DR_CNT  = 7'b0100000,
    ST_DR_EMIT = 7'b1000000
  } state_t;

endpackage

### rtl/line_term_frequency_counter.sv
// Line term-frequency counter: sequencer around a count RAM and a distinct-word list RAM.
// Word item: transfer, then read-modify-write of the count RAM; in_stall is high during the update.
// Line end: per distinct word a list read, a count read, then emit and clear; an empty
//   line emits a single result. The result side can hold either with out_stall.
// Reset: synchronous rst_n starts a pass that zeroes all 4096 count RAM entries;
//   in_stall stays high until it finishes.
module line_term_frequency_counter
  import lftc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ID_W-1:0]    in_word_id,
  input  logic               in_word_valid,
  input  logic               in_line_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [TOTAL_W-1:0] out_distinct_total,
  output logic [NUM_W-1:0]   out_word_number,
  output logic [OCC_W-1:0]   out_occurrences,
  output logic               out_overflow,
  output logic               out_last_of_line
);

  // ---------------------------------------------------------------------------
  // Sequencer and line state
  // ---------------------------------------------------------------------------
  state_t              st_r, st_nxt;
  logic [VOCAB_AW-1:0] clr_r, clr_nxt;      // clearing pass address
  logic [TOTAL_W-1:0]  fill_r, fill_nxt;    // distinct words in this line
  logic                dropped_r, dropped_nxt;
  logic [LIST_AW-1:0]  j_r, j_nxt;          // drain position in the list
  logic [ID_W-1:0]     id_r, id_nxt;        // word under update
  logic                wv_r, wv_nxt;        // word present and in vocabulary
  logic                end_r, end_nxt;
  logic [ID_W-1:0]     w_r, w_nxt;          // word being drained

  // RAM ports
  logic                cnt_we;
  logic [VOCAB_AW-1:0] cnt_waddr, cnt_raddr;
  count_t              cnt_wdata, cnt_rdata;
  logic                lst_we;
  logic [ID_W-1:0]     lst_rdata;

  // result register
  logic load, load_ok;
  res_t res;

  logic in_xfer;
  logic list_full;
  logic is_last;
  logic [OCC_W-1:0] occ_clip;

  assign in_stall  = (st_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign list_full = (fill_r == TOTAL_W'(MAX_DISTINCT));
  assign is_last   = ((TOTAL_W'(j_r) + TOTAL_W'(1)) == fill_r);
  assign occ_clip  = (32'(cnt_rdata) > 32'(OCC_MAX)) ? OCC_MAX : OCC_W'(cnt_rdata);

  // count RAM read address: the incoming word while idle, the list entry
  // just read during a drain, otherwise the held drain word
  always_comb begin
    case (st_r)
      ST_IDLE:   cnt_raddr = VOCAB_AW'(in_word_id);
      ST_DR_CNT: cnt_raddr = VOCAB_AW'(lst_rdata);
      default:   cnt_raddr = VOCAB_AW'(w_r);
    endcase
  end

  always_comb begin
    st_nxt      = st_r;
    clr_nxt     = clr_r;
    fill_nxt    = fill_r;
    dropped_nxt = dropped_r;
    j_nxt       = j_r;
    id_nxt      = id_r;
    wv_nxt      = wv_r;
    end_nxt     = end_r;
    w_nxt       = w_r;
    cnt_we      = 1'b0;
    cnt_waddr   = VOCAB_AW'(w_r);
    cnt_wdata   = '0;
    lst_we      = 1'b0;
    load        = 1'b0;
    res         = '0;

    case (st_r)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        clr_nxt   = clr_r + VOCAB_AW'(1);
        if (clr_r == VOCAB_AW'(VOCAB_SIZE - 1)) begin
          st_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          id_nxt  = in_word_id;
          wv_nxt  = in_word_valid && (32'(in_word_id) < 32'(VOCAB_SIZE));
          end_nxt = in_line_end;
          st_nxt  = ST_RMW;
        end
      end

      ST_RMW: begin
        cnt_waddr = VOCAB_AW'(id_r);
        if (wv_r) begin
          if (cnt_rdata != '0) begin
            cnt_we    = 1'b1;
            cnt_wdata = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + count_t'(1);
          end else if (list_full) begin
            dropped_nxt = 1'b1;
          end else begin
            // first sighting: append to list, count starts at one
            lst_we    = 1'b1;
            cnt_we    = 1'b1;
            cnt_wdata = count_t'(1);
            fill_nxt  = fill_r + TOTAL_W'(1);
          end
        end
        if (!end_r) begin
          st_nxt = ST_IDLE;
        end else if (fill_nxt == '0) begin
          st_nxt = ST_EMPTY;
        end else begin
          j_nxt  = '0;
          st_nxt = ST_DR_LIST;
        end
      end

      ST_EMPTY: begin
        if (load_ok) begin
          load             = 1'b1;
          res.overflow     = dropped_r;
          res.last_of_line = 1'b1;
          fill_nxt         = '0;
          dropped_nxt      = 1'b0;
          st_nxt           = ST_IDLE;
        end
      end

      ST_DR_LIST: begin
        st_nxt = ST_DR_CNT;
      end

      ST_DR_CNT: begin
        w_nxt  = lst_rdata;
        st_nxt = ST_DR_EMIT;
      end

      ST_DR_EMIT: begin
        if (load_ok) begin
          load               = 1'b1;
          res.distinct_total = fill_r;
          res.word_number    = NUM_W'(w_r) + NUM_W'(1);
          res.occurrences    = occ_clip;
          res.overflow       = dropped_r;
          res.last_of_line   = is_last;
          // clear the count behind the emitted word
          cnt_we             = 1'b1;
          cnt_wdata          = '0;
          if (is_last) begin
            fill_nxt    = '0;
            dropped_nxt = 1'b0;
            st_nxt      = ST_IDLE;
          end else begin
            j_nxt  = j_r + LIST_AW'(1);
            st_nxt = ST_DR_LIST;
          end
        end
      end

      default: begin
        st_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_CLEAR;
      clr_r     <= '0;
      fill_r    <= '0;
      dropped_r <= 1'b0;
      j_r       <= '0;
      wv_r      <= 1'b0;
      end_r     <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      clr_r     <= clr_nxt;
      fill_r    <= fill_nxt;
      dropped_r <= dropped_nxt;
      j_r       <= j_nxt;
      wv_r      <= wv_nxt;
      end_r     <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    w_r  <= w_nxt;
  end

  // ---------------------------------------------------------------------------
  // Storage
  // ---------------------------------------------------------------------------
  lftc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (VOCAB_SIZE)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  lftc_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_DISTINCT)
  ) u_list_ram (
    .clk   (clk),
    .we    (lst_we),
    .waddr (fill_r[LIST_AW-1:0]),
    .wdata (id_r),
    .raddr (j_r),
    .rdata (lst_rdata)
  );

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  lftc_outreg u_outreg (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (load),
    .res                (res),
    .ready              (load_ok),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_distinct_total (out_distinct_total),
    .out_word_number    (out_word_number),
    .out_occurrences    (out_occurrences),
    .out_overflow       (out_overflow),
    .out_last_of_line   (out_last_of_line)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= TOTAL_W'(MAX_DISTINCT))
    else $error("distinct fill beyond list capacity");

  a_xfer_to_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (st_r == ST_RMW))
    else $error("accepted word not followed by count update");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (load && load_ok && res.last_of_line) |=> (fill_r == '0 && !dropped_r))
    else $error("line state not cleared after final result");

  a_no_write_on_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cnt_we && in_xfer))
    else $error("count RAM written while taking a word");

endmodule

### rtl/lftc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lftc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/lftc_outreg.sv
// Result holding register: keeps one result until the receiver takes it.
module lftc_outreg
  import lftc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  res_t               res,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [TOTAL_W-1:0] out_distinct_total,
  output logic [NUM_W-1:0]   out_word_number,
  output logic [OCC_W-1:0]   out_occurrences,
  output logic               out_overflow,
  output logic               out_last_of_line
);

  logic valid_r;
  res_t res_r;

  // free when empty or when the held result transfers this cycle
  assign ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      res_r <= res;
    end
  end

  assign out_valid          = valid_r;
  assign out_distinct_total = res_r.distinct_total;
  assign out_word_number    = res_r.word_number;
  assign out_occurrences    = res_r.occurrences;
  assign out_overflow       = res_r.overflow;
  assign out_last_of_line   = res_r.last_of_line;

endmodule

### verif/line_term_frequency_counter_test.sv
// Self-checking testbench for the line term-frequency counter: directed lines, then random ones.
module line_term_frequency_counter_test;
  import lftc_pkg::*;

  // Run bounds. A correct run takes the clearing pass plus the word traffic; the limit
  // covers every item closing a full line under heavy stalls.
  localparam int CYCLE_LIMIT    = 200_000;
  localparam int RANDOM_WORDS   = 32;
  // Tail after the last result: sized for a full list drain plus stalls.
  localparam int LATENCY_TAIL   = 3 * MAX_DISTINCT + 64;
  localparam int MAX_PRINTED    = 40;

  typedef struct {
    logic [ID_W-1:0] id;
    bit              has_word;
    bit              closes;
    bit              drain_first;  // hold this transfer until every result is back
  } word_item_t;

  logic               clk;
  logic               rst_n              = 1'b0;
  logic               in_valid           = 1'b0;
  logic               in_stall;
  logic [ID_W-1:0]    in_word_id         = '0;
  logic               in_word_valid      = 1'b0;
  logic               in_line_end        = 1'b0;
  logic               out_valid;
  logic               out_stall          = 1'b0;
  logic [TOTAL_W-1:0] out_distinct_total;
  logic [NUM_W-1:0]   out_word_number;
  logic [OCC_W-1:0]   out_occurrences;
  logic               out_overflow;
  logic               out_last_of_line;

  line_term_frequency_counter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_word_id         (in_word_id),
    .in_word_valid      (in_word_valid),
    .in_line_end        (in_line_end),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_distinct_total (out_distinct_total),
    .out_word_number    (out_word_number),
    .out_occurrences    (out_occurrences),
    .out_overflow       (out_overflow),
    .out_last_of_line   (out_last_of_line)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stimulus queue and expected line results
  word_item_t pending [$];
  res_t       expected_counts [$];
  word_item_t cur_item;

  // Shadow of the block's per-line state
  count_t          tally [VOCAB_SIZE];
  logic [ID_W-1:0] seen_list [MAX_DISTINCT];
  int unsigned     seen_fill;
  bit              dropped;

  int cycle_cnt       = 0;
  int total_items     = 0;
  int items_accepted  = 0;
  int results_checked = 0;
  int errors          = 0;
  int lines_closed    = 0;
  int empty_lines     = 0;
  int overflow_lines  = 0;
  int widest_line     = 0;

  // Periodic calm window: late in each period of cycle_cnt neither side idles.
  function automatic bit roll_idle();
    return ($urandom_range(99) < 6) && ((cycle_cnt % 2000) < 1400);
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTED) $display("mismatch @%0d: %s", cycle_cnt, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int idx,
                             input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", idx, name, got, want));
  endtask

  function automatic void add_item(input logic [ID_W-1:0] id, input bit has_word,
                                   input bit closes, input bit drain_first = 1'b0);
    word_item_t it;
    it.id          = id;
    it.has_word    = has_word;
    it.closes      = closes;
    it.drain_first = drain_first;
    pending.push_back(it);
    total_items++;
  endfunction

  // Count one word, and on a line end queue the per-word results in first-seen order, or one result for an empty line.
  function automatic void predict_line_counts(input word_item_t it);
    res_t r;
    if (it.has_word && int'(it.id) < VOCAB_SIZE) begin
      if (tally[it.id] != '0) begin
        if (tally[it.id] != COUNT_MAX) tally[it.id] = tally[it.id] + 1'b1;
      end else if (seen_fill >= MAX_DISTINCT) begin
        dropped = 1'b1;                  // list full: new word and its repeats are lost
      end else begin
        seen_list[seen_fill] = it.id;
        seen_fill++;
        tally[it.id] = count_t'(1);
      end
    end
    if (!it.closes) return;
    lines_closed++;
    if (dropped) overflow_lines++;
    if (int'(seen_fill) > widest_line) widest_line = int'(seen_fill);
    if (seen_fill == 0) begin
      empty_lines++;
      r.distinct_total = '0;
      r.word_number    = '0;
      r.occurrences    = '0;
      r.overflow       = dropped;
      r.last_of_line   = 1'b1;
      expected_counts.push_back(r);
    end else begin
      for (int unsigned k = 0; k < seen_fill; k++) begin
        r.distinct_total = TOTAL_W'(seen_fill);
        r.word_number    = NUM_W'(seen_list[k]) + 1'b1;
        r.occurrences    = (tally[seen_list[k]] > count_t'(OCC_MAX)) ? OCC_MAX
                                                                     : OCC_W'(tally[seen_list[k]]);
        r.overflow       = dropped;
        r.last_of_line   = (k + 1 == seen_fill);
        tally[seen_list[k]] = '0;
        expected_counts.push_back(r);
      end
    end
    seen_fill = 0;
    dropped   = 1'b0;
  endfunction

  // Driver: a transfer happens on valid && !stall; a new item goes out only when the
  // slot is free, so valid never drops while stalled and the payload holds.
  always @(posedge clk) begin : feed
    logic launch;
    launch = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_line_counts(cur_item);
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending.size() != 0 && !(pending[0].drain_first && expected_counts.size() != 0)
            && !roll_idle()) begin
          cur_item = pending.pop_front();
          launch   = 1'b1;
          in_word_id    <= cur_item.id;
          in_word_valid <= cur_item.has_word;
          in_line_end   <= cur_item.closes;
        end
        in_valid <= launch;
      end
    end
  end

  // Monitor: each result transfer is checked against the oldest expectation.
  always @(posedge clk) begin : observe
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected (word %0d count %0d)",
                                    results_checked, out_word_number, out_occurrences));
        end else begin
          want = expected_counts.pop_front();
          check_field("distinct_total", results_checked, 16'(out_distinct_total),
                      16'(want.distinct_total));
          check_field("word_number", results_checked, 16'(out_word_number),
                      16'(want.word_number));
          check_field("occurrences", results_checked, out_occurrences, want.occurrences);
          check_field("overflow", results_checked, 16'(out_overflow), 16'(want.overflow));
          check_field("last_of_line", results_checked, 16'(out_last_of_line),
                      16'(want.last_of_line));
        end
        results_checked++;
      end
      out_stall <= roll_idle();
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt,
               expected_counts.size());
      $display("FAIL line_term_frequency_counter");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ID_W-1:0] pool [6];
    int words_made;
    int len;
    bit held;
    bit closed;
    bit last;

    foreach (tally[i]) tally[i] = '0;
    seen_fill = 0;
    dropped   = 1'b0;

    // Directed: empty line straight after reset
    add_item(ID_W'($urandom), 1'b0, 1'b1);
    // Extreme ids, repeats, word counted on the closing transfer
    add_item('0, 1'b1, 1'b0);
    add_item('1, 1'b1, 1'b0);
    add_item('0, 1'b1, 1'b0);
    add_item('1, 1'b1, 1'b1);
    // Alternating bit patterns, ignored item mid-line, bare line end
    add_item(12'hAAA, 1'b1, 1'b0);
    add_item(ID_W'($urandom), 1'b0, 1'b0);
    add_item(12'h555, 1'b1, 1'b0);
    add_item(12'hAAA, 1'b1, 1'b0);
    add_item(12'hFFF, 1'b0, 1'b1);
    // One-word line, then two empty lines back to back
    add_item(12'h123, 1'b1, 1'b1);
    add_item(ID_W'($urandom), 1'b0, 1'b1);
    add_item(ID_W'($urandom), 1'b0, 1'b1);

    // List exactly full: no drop
    for (int i = 0; i < MAX_DISTINCT; i++)
      add_item(ID_W'(i * 61 + 5), 1'b1, i == MAX_DISTINCT - 1);
    // List overflow: two extra distinct words, a repeat of a kept one and of a dropped one
    for (int i = 0; i < MAX_DISTINCT + 2; i++)
      add_item(ID_W'(i * 37 + 900), 1'b1, 1'b0);
    add_item(ID_W'(900), 1'b1, 1'b0);
    add_item(ID_W'(MAX_DISTINCT * 37 + 900), 1'b1, 1'b0);
    add_item(ID_W'($urandom), 1'b0, 1'b1);
    // Flag must be clear again on the next line
    add_item(ID_W'($urandom), 1'b0, 1'b1);

    // One-word line; the sender first waits for the block to drain completely
    add_item(ID_W'(1), 1'b1, 1'b1, 1'b1);

    // Random lines: short, words drawn from a small per-line pool so repeats are
    // common, with stray ignored items and now and then an empty line.
    words_made = 0;
    held       = 1'b0;
    while (words_made < RANDOM_WORDS) begin
      foreach (pool[i]) pool[i] = ID_W'($urandom);
      if ($urandom_range(8) == 0) len = 0;
      else len = $urandom_range(1, 10);
      closed = 1'b0;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(11) == 0) add_item(ID_W'($urandom), 1'b0, 1'b0);
        last   = (i == len - 1) && $urandom_range(1);
        closed = last;
        add_item(($urandom_range(3) != 0 && len <= 10) ? pool[$urandom_range(5)]
                                                       : ID_W'($urandom),
                 1'b1, last, !held && i == 0 && words_made >= RANDOM_WORDS / 2);
        if (!held && i == 0 && words_made >= RANDOM_WORDS / 2) held = 1'b1;
      end
      // Occasionally leave a line open so it runs into the next one
      if (!closed && ($urandom_range(9) != 0 || words_made + len >= RANDOM_WORDS))
        add_item(ID_W'($urandom), 1'b0, 1'b1);
      words_made += len;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (!(items_accepted == total_items && expected_counts.size() == 0)) @(posedge clk);
    repeat (LATENCY_TAIL) @(posedge clk);

    if (expected_counts.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_counts.size()));
    $display("covered %0d lines: %0d empty, %0d over capacity, widest %0d distinct words",
             lines_closed, empty_lines, overflow_lines, widest_line);
    $display("checked %0d results from %0d transfers, %0d mismatches",
             results_checked, items_accepted, errors);
    if (errors == 0) begin
      $display("PASS line_term_frequency_counter");
    end else begin
      $display("FAIL line_term_frequency_counter");
    end
    $finish;
  end

endmodule
